// ===== hw/rtl/sitoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int DEFAULT_WIDTH = 32;
  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 7;
  localparam int BITS_PER_STEP = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SIGN,
    ST_DIGIT
  } sitoa_state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic norm;
    logic emit_sign;
    logic emit_digit;
  } sitoa_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic negative;
    logic digit_last;
    logic out_free;
  } sitoa_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sitoa_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_in_if
// Request channel carrying one signed integer per request.
// ----------------------------------------------------------------------------
interface sitoa_in_if
  import sitoa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sitoa_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_out_if
// Result channel carrying one ASCII character per transfer.
// ----------------------------------------------------------------------------
interface sitoa_out_if
  import sitoa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sitoa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_ctrl
// Sequencer: accept, convert to BCD, find the leading digit, emit characters.
// ----------------------------------------------------------------------------
module sitoa_ctrl
  import sitoa_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sitoa_status_t status,
  output sitoa_cmd_t         cmd
);

  sitoa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (status.conv_done) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        state_nxt = status.negative ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (status.out_free) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (status.out_free && status.digit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV:  cmd.conv_step  = 1'b1;
      ST_NORM:  cmd.norm       = 1'b1;
      ST_SIGN:  cmd.emit_sign  = status.out_free;
      ST_DIGIT: cmd.emit_digit = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sitoa_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_dpath
// Magnitude, shift-and-add-3 BCD conversion, digit index and output register.
// ----------------------------------------------------------------------------
module sitoa_dpath
  import sitoa_pkg::*;
#(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sitoa_cmd_t         cmd,
  output sitoa_status_t           status,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [CHAR_W-1:0]       out_char_code,
  output logic                    out_is_last
);

  localparam int STEPS  = (WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W  = STEPS * BITS_PER_STEP;
  // Decimal digits of 2^WIDTH - 1: floor(WIDTH * log10(2)) + 1.
  localparam int NDIG   = (WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W  = NDIG * 4;
  localparam int IDX_W  = $clog2(NDIG);
  localparam int STEP_W = $clog2(STEPS);

  logic [WIDTH-1:0]  raw;
  logic [WIDTH-1:0]  mag;
  logic [PAD_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  top_idx;
  logic [3:0]        cur_digit;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  if (WIDTH <= VALUE_W) begin : g_narrow
    assign raw = in_value[WIDTH-1:0];
  end else begin : g_wide
    assign raw = {{(WIDTH - VALUE_W){1'b0}}, in_value};
  end

  // The most negative value negates to itself, which is its correct
  // unsigned magnitude.
  assign mag = raw[WIDTH-1] ? (~raw + 1'b1) : raw;

  // One step shifts BITS_PER_STEP binary bits into the BCD register.
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int k = 0; k < NDIG; k++) begin
        if (bcd_nxt[k*4 +: 4] >= 4'd5) bcd_nxt[k*4 +: 4] = bcd_nxt[k*4 +: 4] + 4'd3;
      end
      bcd_nxt = {bcd_nxt[BCD_W-2:0], bin_nxt[PAD_W-1]};
      bin_nxt = {bin_nxt[PAD_W-2:0], 1'b0};
    end
  end

  // Highest nonzero digit; zero leaves a single digit.
  always_comb begin
    top_idx = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (bcd_r[k*4 +: 4] != 4'd0) top_idx = IDX_W'(k);
    end
  end

  assign cur_digit = bcd_r[{idx_r, 2'b00} +: 4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r  <= PAD_W'(mag);
      bcd_r  <= '0;
      step_r <= '0;
      neg_r  <= raw[WIDTH-1];
    end else if (cmd.conv_step) begin
      bin_r  <= bin_nxt;
      bcd_r  <= bcd_nxt;
      step_r <= step_r + 1'b1;
    end
    if (cmd.norm) begin
      idx_r <= top_idx;
    end else if (cmd.emit_digit) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= CHAR_ZERO + CHAR_W'(cur_digit);
      out_last_r <= (idx_r == '0);
    end
  end

  assign status.conv_done  = (step_r == STEP_W'(STEPS - 1));
  assign status.negative   = neg_r;
  assign status.digit_last = (idx_r == '0);
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_is_last   = out_last_r;

endmodule
`default_nettype wire

// ===== hw/rtl/signed_int_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed two's complement integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
// A request on in_ch carries one integer; its low WIDTH bits are converted.
// out_ch returns the text one character per transfer, most significant first,
// with a leading '-' for negative values and is_last set on the final digit.
// Zero gives the single character '0'; no terminator is sent.
// After a request is taken, shift-and-add-3 steps build the BCD digits,
// the normalising state then finds the leading digit, and then one character
// per cycle is loaded into the output register while the receiver is ready.
// The next request is accepted once the last character is loaded, even
// while it still waits in the output register. When the receiver stalls,
// the output register holds its character and emission pauses.
// Reset returns the sequencer to idle and drops out_ch.valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
  import sitoa_pkg::*;
#(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sitoa_in_if.sink    in_ch,
  sitoa_out_if.source out_ch
);

  sitoa_cmd_t    cmd;
  sitoa_status_t status;

  sitoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sitoa_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_value      (in_ch.value),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_char_code (out_ch.char_code),
    .out_is_last   (out_ch.is_last)
  );

endmodule
`default_nettype wire
